[rtl/core/wqtbs_pkg.sv]
// ----------------------------------------------------------------------------
// wqtbs_pkg: shared types and constants of the wall quad texel band slicer
// Holds the divider widths and the status record the divider hands back.
// ----------------------------------------------------------------------------
`default_nettype none
package wqtbs_pkg;
  localparam int unsigned DvdW = 34;   // rounded numerator 2|p| + |den|
  localparam int unsigned DivW = 17;   // divisor 2|den|
  localparam int unsigned QuoW = 18;   // quotient bits produced
  localparam int unsigned CntW = 5;    // step counter width

  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;
endpackage
`default_nettype wire

[rtl/core/wqtbs_div.sv]
// ----------------------------------------------------------------------------
// wqtbs_div: restoring divider, one quotient bit per cycle
// Divides a 34-bit value by a 17-bit one whose quotient is known to fit 18 bits.
// ----------------------------------------------------------------------------
`default_nettype none
module wqtbs_div (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [wqtbs_pkg::DvdW-1:0]   dividend_i,
  input  logic [wqtbs_pkg::DivW-1:0]   divisor_i,
  output logic [wqtbs_pkg::QuoW-1:0]   quot_o,
  output wqtbs_pkg::div_status_t       status_o
);
  import wqtbs_pkg::*;

  logic [DivW-1:0] rem_q, rem_d;
  logic [QuoW-1:0] low_q, low_d;
  logic [QuoW-1:0] quo_q, quo_d;
  logic [DivW-1:0] dsr_q, dsr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            busy_q, busy_d, done_q, done_d;
  logic [DivW:0]   rem_sh;
  logic            fits;

  assign rem_sh = {rem_q, low_q[QuoW-1]};
  assign fits   = rem_sh >= {1'b0, dsr_q};

  always_comb begin
    rem_d  = rem_q;
    low_d  = low_q;
    quo_d  = quo_q;
    dsr_d  = dsr_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      // The top part of the dividend is already below the divisor.
      rem_d  = {1'b0, dividend_i[DvdW-1:QuoW]};
      low_d  = dividend_i[QuoW-1:0];
      dsr_d  = divisor_i;
      quo_d  = '0;
      cnt_d  = CntW'(QuoW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d = fits ? DivW'(rem_sh - {1'b0, dsr_q}) : rem_sh[DivW-1:0];
      low_d = {low_q[QuoW-2:0], 1'b0};
      quo_d = {quo_q[QuoW-2:0], fits};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    low_q <= low_d;
    quo_q <= quo_d;
    dsr_q <= dsr_d;
  end

  assign quot_o        = quo_q;
  assign status_o.busy = busy_q;
  assign status_o.done = done_q;
endmodule
`default_nettype wire

[rtl/core/wall_quad_texel_band_slicer.sv]
// ----------------------------------------------------------------------------
// wall_quad_texel_band_slicer: cuts a wall quad's texel span into row bands
// Orders and clamps the texel span, rounds it to whole rows, splits it into
// bands and interpolates the four screen Y corners of every band.
// ----------------------------------------------------------------------------
// The block takes one wall quad at a time and holds in_ready_o low until the
// last band of that wall has been taken. A quad goes through setup, then for
// every band (at most eight) a band-bounds step, four corner interpolations
// (multiply, sign handling, divide through the single shared restoring
// divider, add) and the output beat, which waits for out_ready_i. A
// degenerate span returns to idle after setup with no beat.
`default_nettype none
module wall_quad_texel_band_slicer #(
  parameter int unsigned BAND_ROWS        = 32,
  parameter int unsigned MAX_TEXTURE_ROWS = 256
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic signed [15:0] y_top_left_i,
  input  logic signed [15:0] y_top_right_i,
  input  logic signed [15:0] y_bot_left_i,
  input  logic signed [15:0] y_bot_right_i,
  input  logic signed [15:0] texel_top_i,
  input  logic signed [15:0] texel_bottom_i,
  input  logic        [8:0]  texture_rows_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic        [7:0]  load_row_first_o,
  output logic        [8:0]  load_row_end_o,
  output logic        [14:0] slice_t_top_o,
  output logic        [14:0] slice_t_bottom_o,
  output logic signed [15:0] slice_y_top_left_o,
  output logic signed [15:0] slice_y_bot_left_o,
  output logic signed [15:0] slice_y_top_right_o,
  output logic signed [15:0] slice_y_bot_right_o,
  output logic               last_band_o
);
  import wqtbs_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SETUP = 3'd1;
  localparam logic [2:0] S_BAND  = 3'd2;
  localparam logic [2:0] S_MUL   = 3'd3;
  localparam logic [2:0] S_ABS   = 3'd4;
  localparam logic [2:0] S_DIV   = 3'd5;
  localparam logic [2:0] S_OUT   = 3'd6;

  logic [2:0] state_q, state_d;

  // Latched quad.
  logic signed [15:0] ytl_q, ytr_q, ybl_q, ybr_q, t0_q, t1_q;
  logic        [8:0]  trows_q;

  // Per-wall values.
  logic signed [16:0] dyl_q, dyr_q;
  logic        [14:0] lo_q, hi_q;
  logic        [8:0]  endr_q;
  logic        [15:0] md_q;
  logic               span_neg_q;

  // Per-band values.
  logic [9:0]         b0_q, b1_q;
  logic [14:0]        tt_q, tb_q;
  logic signed [16:0] numt_q, numb_q;
  logic               last_q;
  logic [2:0]         n_q;
  logic [1:0]         k_q;

  logic signed [33:0] p_q;
  logic               neg_q;
  logic signed [15:0] yo_q [4];

  // Setup combinational values.
  logic        [8:0]  rows_c;
  logic signed [16:0] lo_s, hi_s, lo_c, hi_c, rows64, span_c;
  logic        [15:0] hi_up;
  logic        [9:0]  endr_raw;
  logic               empty_c;

  always_comb begin
    rows_c = ({2'b0, trows_q} > 11'(MAX_TEXTURE_ROWS)) ? 9'(MAX_TEXTURE_ROWS) : trows_q;
    rows64 = {2'b0, rows_c, 6'b0};
    lo_s   = (t0_q < t1_q) ? 17'(t0_q) : 17'(t1_q);
    hi_s   = (t0_q < t1_q) ? 17'(t1_q) : 17'(t0_q);
    lo_c   = (lo_s < 0) ? '0 : lo_s;
    hi_c   = (hi_s > rows64) ? rows64 : hi_s;
    span_c = 17'(t1_q) - 17'(t0_q);
    empty_c = (rows_c == '0) || (hi_c <= lo_c) || (span_c == '0);
    hi_up  = {1'b0, hi_c[14:0]} + 16'd63;
    endr_raw = hi_up[15:6];
  end

  // Band combinational values.
  logic [9:0]  bsum, b1_c;
  logic [14:0] bt0_c, bt1_c, b0x64, b1x64;

  always_comb begin
    bsum  = b0_q + 10'(BAND_ROWS);
    b1_c  = (bsum > {1'b0, endr_q}) ? {1'b0, endr_q} : bsum;
    b0x64 = {b0_q[8:0], 6'b0};
    b1x64 = {b1_c[8:0], 6'b0};
    bt0_c = (b0x64 < lo_q) ? lo_q : b0x64;
    bt1_c = (b1x64 > hi_q) ? hi_q : b1x64;
  end

  // Interpolation operand selection: k picks the corner.
  logic signed [16:0] dy_sel, num_sel;
  logic signed [15:0] y0_sel;
  always_comb begin
    dy_sel  = k_q[1] ? dyr_q : dyl_q;
    y0_sel  = k_q[1] ? ytr_q : ytl_q;
    num_sel = k_q[0] ? numb_q : numt_q;
  end

  // Divider hookup.
  logic [33:0]        mp_c;
  logic [34:0]        nsum;
  logic               div_start;
  logic [QuoW-1:0]    quot;
  div_status_t        div_st;
  logic signed [18:0] ysum;

  assign mp_c      = p_q[33] ? 34'(-p_q) : 34'(p_q);
  assign nsum      = {mp_c, 1'b0} + 35'(md_q);
  assign div_start = (state_q == S_ABS);
  assign ysum      = 19'(y0_sel) + (neg_q ? -$signed({1'b0, quot}) : $signed({1'b0, quot}));

  wqtbs_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (nsum[DvdW-1:0]),
    .divisor_i  ({md_q, 1'b0}),
    .quot_o     (quot),
    .status_o   (div_st)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:  if (in_valid_i) state_d = S_SETUP;
      S_SETUP: state_d = empty_c ? S_IDLE : S_BAND;
      S_BAND:  state_d = S_MUL;
      S_MUL:   state_d = S_ABS;
      S_ABS:   state_d = S_DIV;
      S_DIV:   if (div_st.done) state_d = (k_q == 2'd3) ? S_OUT : S_MUL;
      S_OUT:   if (out_ready_i) state_d = last_q ? S_IDLE : S_BAND;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      b0_q    <= '0;
      endr_q  <= '0;
      n_q     <= '0;
      k_q     <= '0;
    end else begin
      state_q <= state_d;
      case (state_q)
        S_SETUP: begin
          b0_q   <= {1'b0, lo_c[14:6]};
          endr_q <= (endr_raw > {1'b0, rows_c}) ? rows_c : endr_raw[8:0];
          n_q    <= '0;
        end
        S_BAND:  k_q <= '0;
        S_DIV:   if (div_st.done) k_q <= k_q + 2'd1;
        S_OUT: begin
          if (out_ready_i && !last_q) begin
            b0_q <= b1_q;
            n_q  <= n_q + 3'd1;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && in_valid_i) begin
      ytl_q   <= y_top_left_i;
      ytr_q   <= y_top_right_i;
      ybl_q   <= y_bot_left_i;
      ybr_q   <= y_bot_right_i;
      t0_q    <= texel_top_i;
      t1_q    <= texel_bottom_i;
      trows_q <= texture_rows_i;
    end
    if (state_q == S_SETUP) begin
      dyl_q      <= 17'(ybl_q) - 17'(ytl_q);
      dyr_q      <= 17'(ybr_q) - 17'(ytr_q);
      lo_q       <= lo_c[14:0];
      hi_q       <= hi_c[14:0];
      md_q       <= span_c[16] ? 16'(-span_c) : span_c[15:0];
      span_neg_q <= span_c[16];
    end
    if (state_q == S_BAND) begin
      b1_q   <= b1_c;
      tt_q   <= span_neg_q ? bt1_c : bt0_c;
      tb_q   <= span_neg_q ? bt0_c : bt1_c;
      numt_q <= $signed({2'b0, (span_neg_q ? bt1_c : bt0_c)}) - 17'(t0_q);
      numb_q <= $signed({2'b0, (span_neg_q ? bt0_c : bt1_c)}) - 17'(t0_q);
      last_q <= (b1_c >= {1'b0, endr_q}) || (n_q == 3'd7);
    end
    if (state_q == S_MUL) p_q <= dy_sel * num_sel;
    if (state_q == S_ABS) neg_q <= p_q[33] ^ span_neg_q;
    if (state_q == S_DIV && div_st.done) yo_q[k_q] <= ysum[15:0];
  end

  assign in_ready_o          = (state_q == S_IDLE);
  assign out_valid_o         = (state_q == S_OUT);
  assign load_row_first_o    = b0_q[7:0];
  assign load_row_end_o      = b1_q[8:0];
  assign slice_t_top_o       = tt_q;
  assign slice_t_bottom_o    = tb_q;
  assign slice_y_top_left_o  = yo_q[0];
  assign slice_y_bot_left_o  = yo_q[1];
  assign slice_y_top_right_o = yo_q[2];
  assign slice_y_bot_right_o = yo_q[3];
  assign last_band_o         = last_q;
endmodule
`default_nettype wire

[rtl/core/wqtbs_checker.sv]
// ----------------------------------------------------------------------------
// wqtbs_checker: port-level checks for the wall quad texel band slicer
// Watches the handshakes and the band sequencing seen on the ports.
// ----------------------------------------------------------------------------
`default_nettype none
module wqtbs_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_o,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input logic        [7:0]  load_row_first_o,
  input logic        [8:0]  load_row_end_o,
  input logic               last_band_o
);
  // The block works on one wall at a time, so it never offers a beat while idle.
  a_not_both: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o)) else $error("ready while a band is pending");

  a_busy_after_in: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o) else $error("took a second quad");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> out_valid_o && $stable(load_row_first_o)
      && $stable(last_band_o)) else $error("stalled beat changed");

  a_band_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i && !last_band_o) |=> !in_ready_o)
    else $error("wall ended before its last band");

  a_band_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ({1'b0, load_row_first_o} < load_row_end_o))
    else $error("empty band");
endmodule

bind wall_quad_texel_band_slicer wqtbs_checker u_wqtbs_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_valid_i       (in_valid_i),
  .in_ready_o       (in_ready_o),
  .out_valid_o      (out_valid_o),
  .out_ready_i      (out_ready_i),
  .load_row_first_o (load_row_first_o),
  .load_row_end_o   (load_row_end_o),
  .last_band_o      (last_band_o)
);
`default_nettype wire

[bench/wall_quad_texel_band_slicer_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// wall_quad_texel_band_slicer_tb: self-checking bench for the band slicer
// Drives wall quads through the input handshake, predicts every band beat
// from the clamped texel span and compares each output beat field by field.
// ----------------------------------------------------------------------------
module wall_quad_texel_band_slicer_tb;

  localparam int BandRows  = 32;
  localparam int MaxRows   = 256;
  localparam int MaxBands  = 8;
  localparam int CycleCap  = 1500000;

  // One wall quad as it is presented on the input ports.
  typedef struct packed {
    logic signed [15:0] ytl;
    logic signed [15:0] ytr;
    logic signed [15:0] ybl;
    logic signed [15:0] ybr;
    logic signed [15:0] ttop;
    logic signed [15:0] tbot;
    logic        [8:0]  rows;
  } quad_t;

  // One band beat as it appears on the output ports.
  typedef struct packed {
    logic        [7:0]  first;
    logic        [8:0]  endr;
    logic        [14:0] t_top;
    logic        [14:0] t_bot;
    logic        [15:0] y_tl;
    logic        [15:0] y_bl;
    logic        [15:0] y_tr;
    logic        [15:0] y_br;
    logic               last;
  } band_t;

  logic clk_i;
  logic rst_ni;
  logic in_valid_i;
  logic in_ready_o;
  logic signed [15:0] y_top_left_i, y_top_right_i, y_bot_left_i, y_bot_right_i;
  logic signed [15:0] texel_top_i, texel_bottom_i;
  logic [8:0] texture_rows_i;
  logic out_valid_o;
  logic out_ready_i;
  logic [7:0] load_row_first_o;
  logic [8:0] load_row_end_o;
  logic [14:0] slice_t_top_o, slice_t_bottom_o;
  logic signed [15:0] slice_y_top_left_o, slice_y_bot_left_o;
  logic signed [15:0] slice_y_top_right_o, slice_y_bot_right_o;
  logic last_band_o;

  quad_t pending_quads[$];
  band_t expected_bands[$];
  int unsigned error_count;
  int unsigned cycle_count;
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  // Set at the rising edge that took an input beat, read by the driver.
  bit in_taken;

  wall_quad_texel_band_slicer u_dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_ready_o         (in_ready_o),
    .y_top_left_i       (y_top_left_i),
    .y_top_right_i      (y_top_right_i),
    .y_bot_left_i       (y_bot_left_i),
    .y_bot_right_i      (y_bot_right_i),
    .texel_top_i        (texel_top_i),
    .texel_bottom_i     (texel_bottom_i),
    .texture_rows_i     (texture_rows_i),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .load_row_first_o   (load_row_first_o),
    .load_row_end_o     (load_row_end_o),
    .slice_t_top_o      (slice_t_top_o),
    .slice_t_bottom_o   (slice_t_bottom_o),
    .slice_y_top_left_o (slice_y_top_left_o),
    .slice_y_bot_left_o (slice_y_bot_left_o),
    .slice_y_top_right_o(slice_y_top_right_o),
    .slice_y_bot_right_o(slice_y_bot_right_o),
    .last_band_o        (last_band_o)
  );

  always begin
    clk_i = 1'b1;
    #2;
    clk_i = 1'b0;
    #2;
  end

  // Corner Y: y0 + dy * num / den, the quotient rounded to nearest with
  // ties away from zero, done on magnitudes so it is exact.
  function automatic logic [15:0] corner_y(input longint y0, input longint dy,
                                           input longint num, input longint den);
    longint p, mp, md, q;
    bit neg;
    p   = dy * num;
    neg = (p < 0) != (den < 0);
    mp  = (p < 0) ? -p : p;
    md  = (den < 0) ? -den : den;
    q   = (mp * 2 + md) / (md * 2);
    if (neg) q = -q;
    return 16'(y0 + q);
  endfunction

  // Pushes the band beats that one wall quad is expected to produce.
  task automatic predict_bands(input quad_t q);
    int rows, lo, hi, first, endr, span, b0, b1, bt0, bt1, tt, tb, n;
    band_t b;
    rows = int'(q.rows);
    if (rows > MaxRows) rows = MaxRows;
    if (rows < 1) return;
    lo = (q.ttop < q.tbot) ? q.ttop : q.tbot;
    hi = (q.ttop < q.tbot) ? q.tbot : q.ttop;
    if (lo < 0) lo = 0;
    if (hi > rows * 64) hi = rows * 64;
    if (hi <= lo) return;
    first = lo / 64;
    endr  = (hi + 63) / 64;
    if (endr > rows) endr = rows;
    span = int'(q.tbot) - int'(q.ttop);
    if (span == 0) return;
    n = 0;
    for (b0 = first; b0 < endr && n < MaxBands; b0 += BandRows) begin
      b1 = b0 + BandRows;
      if (b1 > endr) b1 = endr;
      bt0 = b0 * 64;
      bt1 = b1 * 64;
      if (bt0 < lo) bt0 = lo;
      if (bt1 > hi) bt1 = hi;
      tt = (span > 0) ? bt0 : bt1;
      tb = (span > 0) ? bt1 : bt0;
      b.first = 8'(b0);
      b.endr  = 9'(b1);
      b.t_top = 15'(tt);
      b.t_bot = 15'(tb);
      b.y_tl  = corner_y(q.ytl, q.ybl - q.ytl, tt - q.ttop, span);
      b.y_bl  = corner_y(q.ytl, q.ybl - q.ytl, tb - q.ttop, span);
      b.y_tr  = corner_y(q.ytr, q.ybr - q.ytr, tt - q.ttop, span);
      b.y_br  = corner_y(q.ytr, q.ybr - q.ytr, tb - q.ttop, span);
      b.last  = (b1 >= endr) || (n == MaxBands - 1);
      expected_bands.push_back(b);
      n++;
    end
  endtask

  task automatic report_mismatch(input string what, input longint got,
                                 input longint want);
    $display("[%0t] mismatch on %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
    error_count++;
  endtask

  task automatic add_quad(input int ytl, input int ytr, input int ybl, input int ybr,
                          input int tt, input int tb, input int rows);
    quad_t q;
    q.ytl  = 16'(ytl);
    q.ytr  = 16'(ytr);
    q.ybl  = 16'(ybl);
    q.ybr  = 16'(ybr);
    q.ttop = 16'(tt);
    q.tbot = 16'(tb);
    q.rows = 9'(rows);
    pending_quads.push_back(q);
  endtask

  function automatic int rand16();
    return int'($urandom_range(0, 65535)) - 32768;
  endfunction

  // Random quad; mostly spans that land inside the texture so bands come out.
  task automatic add_random_quad();
    int rows, tt, tb, sel;
    sel  = $urandom_range(0, 99);
    rows = (sel < 10) ? $urandom_range(0, 511) : $urandom_range(1, 256);
    if (sel < 15) begin
      tt = rand16();
      tb = rand16();
    end else begin
      tt = $urandom_range(0, 16447) - 32;
      tb = $urandom_range(0, 16447) - 32;
    end
    add_quad(rand16(), rand16(), rand16(), rand16(), tt, tb, rows);
  endtask

  // Driver: presents the head of the queue, holding it until accepted.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (in_taken) begin
        // The beat was taken at the last rising edge; retire it.
        void'(pending_quads.pop_front());
      end
      if (!in_valid_i || in_taken) begin
        if (pending_quads.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          in_valid_i     <= 1'b1;
          y_top_left_i   <= pending_quads[0].ytl;
          y_top_right_i  <= pending_quads[0].ytr;
          y_bot_left_i   <= pending_quads[0].ybl;
          y_bot_right_i  <= pending_quads[0].ybr;
          texel_top_i    <= pending_quads[0].ttop;
          texel_bottom_i <= pending_quads[0].tbot;
          texture_rows_i <= pending_quads[0].rows;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
      out_ready_i <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // Monitor: predicts on input beats and checks output beats.
  always @(posedge clk_i) begin
    band_t want;
    if (rst_ni) begin
      cycle_count <= cycle_count + 1;
      in_taken    <= in_valid_i && in_ready_o;
      if (in_valid_i && in_ready_o) begin
        predict_bands({y_top_left_i, y_top_right_i, y_bot_left_i, y_bot_right_i,
                       texel_top_i, texel_bottom_i, texture_rows_i});
      end
      if (out_valid_o && out_ready_i) begin
        if (expected_bands.size() == 0) begin
          report_mismatch("unexpected beat", load_row_first_o, 0);
        end else begin
          want = expected_bands.pop_front();
          if (load_row_first_o !== want.first)
            report_mismatch("load_row_first", load_row_first_o, want.first);
          if (load_row_end_o !== want.endr)
            report_mismatch("load_row_end", load_row_end_o, want.endr);
          if (slice_t_top_o !== want.t_top)
            report_mismatch("slice_t_top", slice_t_top_o, want.t_top);
          if (slice_t_bottom_o !== want.t_bot)
            report_mismatch("slice_t_bottom", slice_t_bottom_o, want.t_bot);
          if (slice_y_top_left_o !== want.y_tl)
            report_mismatch("slice_y_top_left", slice_y_top_left_o, want.y_tl);
          if (slice_y_bot_left_o !== want.y_bl)
            report_mismatch("slice_y_bot_left", slice_y_bot_left_o, want.y_bl);
          if (slice_y_top_right_o !== want.y_tr)
            report_mismatch("slice_y_top_right", slice_y_top_right_o, want.y_tr);
          if (slice_y_bot_right_o !== want.y_br)
            report_mismatch("slice_y_bot_right", slice_y_bot_right_o, want.y_br);
          if (last_band_o !== want.last)
            report_mismatch("last_band", last_band_o, want.last);
        end
      end
    end
  end

  // Timeout watchdog.
  always @(posedge clk_i) begin
    if (cycle_count > CycleCap) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic run_phase(input int unsigned idle_pct, input int unsigned stall_pct,
                           input int count);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    repeat (count) add_random_quad();
    while (pending_quads.size() > 0) @(posedge clk_i);
  endtask

  initial begin
    error_count    = 0;
    cycle_count    = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    in_taken       = 1'b0;
    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    out_ready_i    = 1'b0;
    y_top_left_i   = '0;
    y_top_right_i  = '0;
    y_bot_left_i   = '0;
    y_bot_right_i  = '0;
    texel_top_i    = '0;
    texel_bottom_i = '0;
    texture_rows_i = '0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed walls: field extremes, both span directions, degenerate and
    // zero spans, zero and oversized row counts, and walls needing the full
    // eight bands.
    add_quad(0, 0, 3200, 3200, 0, 2048, 32);
    add_quad(100, -50, 900, 700, 2048, 0, 32);
    add_quad(-32768, 32767, 32767, -32768, 0, 16384, 256);
    add_quad(32767, -32768, -32768, 32767, 16384, 0, 256);
    add_quad(10, 20, 30, 40, 500, 500, 64);
    add_quad(10, 20, 30, 40, -32768, -100, 64);
    add_quad(10, 20, 30, 40, 5000, 32767, 64);
    add_quad(10, 20, 30, 40, 0, 640, 0);
    add_quad(-1000, 1000, 4000, -4000, 0, 32767, 511);
    add_quad(0, 0, 1, 1, -32768, 32767, 300);
    add_quad(-5, 7, 5, -7, 33, 97, 8);
    add_quad(1, 2, 3, 4, 63, 64, 1);
    add_quad(-32768, -32768, -32768, -32768, -32768, 32767, 256);
    add_quad(32767, 32767, 32767, 32767, 32767, -32768, 256);
    add_quad(-21845, 21845, 10922, -10922, 21845, -21846, 256);
    add_quad(555, -555, 0, 0, 3, 16383, 129);
    add_quad(0, 0, 16, 16, 1000, 1, 256);
    add_quad(0, 0, 0, 0, 1, 2, 1);

    // Random walls under changing handshake pressure.
    run_phase(0, 0, 110);
    run_phase(74, 0, 90);
    run_phase(0, 74, 90);
    run_phase(31, 31, 90);

    while (expected_bands.size() > 0) @(posedge clk_i);
    repeat (800) @(posedge clk_i);
    if (error_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
